>>> rtl/core/zel_pkg.sv
`default_nettype none

package zel_pkg;

    // End record geometry
    localparam int RECORD_BYTES = 22;
    localparam int WIN_BYTES    = RECORD_BYTES - 1;
    localparam int LEN_W        = 48;

    // End record signature, first byte first
    localparam logic [7:0] SIG_0 = 8'h50;  // 'P'
    localparam logic [7:0] SIG_1 = 8'h4B;  // 'K'
    localparam logic [7:0] SIG_2 = 8'h05;
    localparam logic [7:0] SIG_3 = 8'h06;

    // Result codes
    typedef enum logic [1:0] {
        STATUS_NOT_FOUND = 2'd0,
        STATUS_ACCEPT    = 2'd1,
        STATUS_REJECT    = 2'd2
    } status_t;

    // One byte of the region as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_scan;
        logic       end_of_region;
    } item_t;

    // One result of a scan
    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] archive_length;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/zel_in_stage.sv
`default_nettype none

module zel_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] data_byte
    input  wire logic          s_tuser,   // [0] start_of_scan
    input  wire logic          s_tlast,   // end_of_region
    input  wire logic          take,
    output logic               item_valid,
    output zel_pkg::item_t     item
);
    import zel_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Accept a new transfer when empty or when the held byte moves on
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Track occupancy of the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Capture the payload of each transfer
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.data_byte     <= s_tdata;
            item_reg.start_of_scan <= s_tuser;
            item_reg.end_of_region <= s_tlast;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/zel_scan.sv
`default_nettype none

module zel_scan (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [zel_pkg::LEN_W-1:0] max_length,
    input  wire zel_pkg::item_t            item,
    input  wire logic                      advance,
    output logic                           res_valid,
    output zel_pkg::result_t               res,
    output logic                           done
);
    import zel_pkg::*;

    logic [7:0]       win_reg  [WIN_BYTES];
    logic [7:0]       win_next [WIN_BYTES];
    logic [LEN_W-1:0] pos_reg;
    logic [LEN_W-1:0] pos_next;
    logic             done_reg;
    logic             done_next;

    logic [LEN_W-1:0] pos_eff;
    logic             done_eff;
    logic             in_range;
    logic             have_rec;
    logic             sig_ok;
    logic [31:0]      cd_size;
    logic [31:0]      cd_offset;
    logic [15:0]      comment_len;
    logic [32:0]      cd_sum;
    logic [LEN_W-1:0] rec_pos;
    logic             hit;
    logic [LEN_W:0]   total;
    logic             fits;
    logic             shift;

    // Start of scan clears position and done before this byte is used.
    // The window needs no clearing: it is refilled before any record test.
    assign pos_eff  = item.start_of_scan ? '0 : pos_reg;
    assign done_eff = item.start_of_scan ? 1'b0 : done_reg;

    assign in_range = pos_eff < max_length;
    assign have_rec = pos_eff >= LEN_W'(WIN_BYTES);

    // Record fields: window holds bytes 0..20, incoming byte is byte 21
    assign sig_ok      = (win_reg[0] == SIG_0) && (win_reg[1] == SIG_1)
                      && (win_reg[2] == SIG_2) && (win_reg[3] == SIG_3);
    assign cd_size     = {win_reg[15], win_reg[14], win_reg[13], win_reg[12]};
    assign cd_offset   = {win_reg[19], win_reg[18], win_reg[17], win_reg[16]};
    assign comment_len = {item.data_byte, win_reg[20]};

    assign cd_sum  = {1'b0, cd_size} + {1'b0, cd_offset};
    assign rec_pos = pos_eff - LEN_W'(WIN_BYTES);

    assign hit = !done_eff && in_range && have_rec && sig_ok
              && ({{(LEN_W-33){1'b0}}, cd_sum} == rec_pos);

    // Record start plus record size plus comment is position plus one plus comment
    assign total = {1'b0, pos_eff} + (LEN_W+1)'(1)
                 + {{(LEN_W-15){1'b0}}, comment_len};
    assign fits  = total <= {1'b0, max_length};

    // Build the result for a match or the end of the region
    always_comb
    begin
        res_valid = !done_eff && (hit || item.end_of_region);
        if (hit && fits)
        begin
            res.status         = STATUS_ACCEPT;
            res.archive_length = total[LEN_W-1:0];
        end
        else if (hit)
        begin
            res.status         = STATUS_REJECT;
            res.archive_length = '0;
        end
        else
        begin
            res.status         = STATUS_NOT_FOUND;
            res.archive_length = '0;
        end
    end

    // Advance window and position for a byte inside the limit, unless the scan is done or the byte matches.
    // pos_eff stays below max_length here, so the count cannot overflow.
    assign shift     = !done_eff && in_range && !hit;
    assign pos_next  = shift ? pos_eff + LEN_W'(1) : pos_eff;
    assign done_next = done_eff || res_valid;

    always_comb
    begin
        for (int i = 0; i < WIN_BYTES - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[WIN_BYTES - 1] = item.data_byte;
    end

    // Update scan state once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

    // Shift the byte window
    always_ff @(posedge clk)
    begin
        if (advance && shift)
        begin
            win_reg <= win_next;
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

>>> rtl/core/zip_end_record_locator.sv
`default_nettype none
// A byte transferred in is held in the input register and is decided when the result
// register has room; a result it causes is then loaded into the result register for m_*.
// Throughput: one byte per cycle while no stalled result holds the result register; the
// add-compare logic on the 21-byte window, the held byte and the position count decides each byte.
// Reset (rst_n, asynchronous, active low) empties both registers, zeroes the
// position count, clears the done flag and sets max_length to zero.

module zip_end_record_locator (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [zel_pkg::LEN_W-1:0] cfg_wdata,  // max_length
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,    // [7:0] data_byte
    input  wire logic                      s_tuser,    // [0] start_of_scan
    input  wire logic                      s_tlast,    // end_of_region
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [zel_pkg::LEN_W-1:0]      m_tdata,    // [47:0] archive_length
    output logic [1:0]                     m_tuser     // [1:0] status
);
    import zel_pkg::*;

    logic [LEN_W-1:0] max_length_reg;
    logic             item_valid;
    item_t            item;
    logic             take;
    logic             res_valid;
    result_t          res;
    logic             scan_done;
    logic             out_valid_reg;
    result_t          out_reg;

    // Hold the length limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            max_length_reg <= cfg_wdata;
        end
    end

    zel_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Process the held byte when the result register has room
    assign take = item_valid && (!out_valid_reg || m_tready);

    zel_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_length (max_length_reg),
        .item       (item),
        .advance    (take),
        .res_valid  (res_valid),
        .res        (res),
        .done       (scan_done)
    );

    // Track the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.archive_length;
    assign m_tuser  = out_reg.status;

`ifndef SYNTHESIS
    // Only defined result codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STATUS_NOT_FOUND || m_tuser == STATUS_ACCEPT
                      || m_tuser == STATUS_REJECT))
        else $error("undefined status code on output");

    // An accepted length never exceeds the limit; other results carry zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == STATUS_ACCEPT) ? (m_tdata <= max_length_reg)
                                                 : (m_tdata == '0)))
        else $error("archive length inconsistent with status");

    // A delivered result closes the scan until the next start
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && res_valid) |=> scan_done)
        else $error("scan not marked done after result");

    // A byte is never processed while a stalled result would be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !take)
        else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

>>> dv/zip_end_record_locator_test.sv
`default_nettype none

module zip_end_record_locator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import zel_pkg::*;

    // Ways to build a region around an end record
    typedef enum int {
        FLAW_NONE,
        FLAW_SIGNATURE,
        FLAW_SUM,
        FLAW_TRUNCATED,
        FLAW_OPEN
    } flaw_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;   // [7:0] data_byte
    logic             s_tuser   = 1'b0; // [0] start_of_scan
    logic             s_tlast   = 1'b0; // end_of_region
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [LEN_W-1:0] m_tdata;          // [47:0] archive_length
    logic [1:0]       m_tuser;          // [1:0] status

    // Scanner state as predicted
    logic [7:0]       tail_bytes [WIN_BYTES];
    logic [LEN_W-1:0] region_pos;
    bit               region_closed;
    logic [LEN_W-1:0] length_limit;
    result_t          pending_reports [$];

    int mismatches    = 0;
    int bytes_taken   = 0;
    int stall_left    = 0;
    bit sender_gaps   = 1'b0;
    bit receiver_gaps = 1'b0;

    zip_end_record_locator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic void clear_region();
        foreach (tail_bytes[k])
            tail_bytes[k] = 8'h00;
        region_pos    = '0;
        region_closed = 1'b0;
    endfunction

    // Advance the predicted scan by one byte and queue any report it causes
    function automatic void scan_byte(logic [7:0] b, bit sos, bit eor);
        logic [7:0]  rec [RECORD_BYTES];
        logic [63:0] rec_pos;
        logic [63:0] cd_sum;
        logic [63:0] total;
        result_t     r;
        if (sos)
            clear_region();
        if (region_closed)
            return;
        if (region_pos < length_limit)
        begin
            if (region_pos >= WIN_BYTES)
            begin
                foreach (tail_bytes[k])
                    rec[k] = tail_bytes[k];
                rec[WIN_BYTES] = b;
                rec_pos = 64'(region_pos) - WIN_BYTES;
                cd_sum  = 64'({rec[15], rec[14], rec[13], rec[12]})
                        + 64'({rec[19], rec[18], rec[17], rec[16]});
                if (rec[0] == SIG_0 && rec[1] == SIG_1 && rec[2] == SIG_2
                    && rec[3] == SIG_3 && cd_sum == rec_pos)
                begin
                    total = rec_pos + RECORD_BYTES + 64'({rec[21], rec[20]});
                    region_closed = 1'b1;
                    if (total <= 64'(length_limit))
                    begin
                        r.status         = STATUS_ACCEPT;
                        r.archive_length = total[LEN_W-1:0];
                    end
                    else
                    begin
                        r.status         = STATUS_REJECT;
                        r.archive_length = '0;
                    end
                    pending_reports.push_back(r);
                    return;
                end
            end
            for (int k = 0; k < WIN_BYTES - 1; k++)
                tail_bytes[k] = tail_bytes[k + 1];
            tail_bytes[WIN_BYTES - 1] = b;
            if (region_pos != '1)
                region_pos = region_pos + 1;
        end
        if (eor)
        begin
            region_closed    = 1'b1;
            r.status         = STATUS_NOT_FOUND;
            r.archive_length = '0;
            pending_reports.push_back(r);
        end
    endfunction

    // Stall the result side in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (receiver_gaps && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 13);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each result transfer with the oldest expected report
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none expected, actual status %0d length %0d",
                         $time, m_tuser, m_tdata);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (m_tuser !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tuser);
                end
                if (m_tdata !== want.archive_length)
                begin
                    mismatches++;
                    $display("%0t: archive_length expected %0d actual %0d",
                             $time, want.archive_length, m_tdata);
                end
            end
        end
    end

    // Offer one byte, hold it until the transfer, then predict
    task automatic send_byte(input logic [7:0] b, input bit sos, input bit eor);
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sos;
        s_tlast  <= eor;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_taken++;
        scan_byte(b, sos, eor);
    endtask

    // Drop valid and wait until every report is in and the pipe is empty
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_length_limit(input logic [LEN_W-1:0] value);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        length_limit = value;
    endtask

    // Region of lead bytes, then an end record pointing back at them, then up to four random bytes
    task automatic send_region(input int lead, input int comment, input flaw_t flaw);
        logic [7:0]  bytes [$];
        logic [31:0] cd_size;
        logic [31:0] cd_offset;
        int          at;
        int          cut;
        repeat (lead)
            bytes.push_back(8'($urandom));
        // Plant a decoy signature in the lead now and then
        if (lead >= 4 && $urandom_range(0, 3) == 0)
        begin
            at = $urandom_range(0, lead - 4);
            bytes[at]     = SIG_0;
            bytes[at + 1] = SIG_1;
            bytes[at + 2] = SIG_2;
            bytes[at + 3] = SIG_3;
        end
        cd_size   = $urandom_range(0, lead);
        cd_offset = lead - cd_size;
        if (flaw == FLAW_SUM)
            cd_offset = $urandom_range(0, 1) ? cd_offset + 32'd1 : cd_offset - 32'd1;
        bytes.push_back(SIG_0);
        bytes.push_back(SIG_1);
        bytes.push_back(SIG_2);
        bytes.push_back(SIG_3);
        repeat (8)
            bytes.push_back(8'($urandom));
        for (int k = 0; k < 4; k++)
            bytes.push_back(8'(cd_size >> (8 * k)));
        for (int k = 0; k < 4; k++)
            bytes.push_back(8'(cd_offset >> (8 * k)));
        bytes.push_back(8'(comment));
        bytes.push_back(8'(comment >> 8));
        if (flaw == FLAW_SIGNATURE)
        begin
            at = lead + $urandom_range(0, 3);
            bytes[at] = bytes[at] ^ 8'(1 << $urandom_range(0, 7));
        end
        if (flaw == FLAW_TRUNCATED)
        begin
            cut = $urandom_range(1, WIN_BYTES);
            repeat (cut)
                void'(bytes.pop_back());
        end
        else
        begin
            repeat ($urandom_range(0, 4))
                bytes.push_back(8'($urandom));
        end
        foreach (bytes[k])
            send_byte(bytes[k], k == 0, flaw != FLAW_OPEN && k == bytes.size() - 1);
    endtask

    // Pick one region at random: mostly intact records, some damaged, some noise
    task automatic random_region(input int max_lead, input bit calm);
        int pick;
        int lead;
        int comment;
        int n;
        sender_gaps   = !calm && $urandom_range(0, 2) != 0;
        receiver_gaps = !calm && $urandom_range(0, 2) != 0;
        pick    = $urandom_range(0, 9);
        lead    = $urandom_range(0, 7) == 0 ? $urandom_range(0, max_lead)
                                            : $urandom_range(0, 24);
        comment = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 40);
        if (pick < 6)
            send_region(lead, comment, FLAW_NONE);
        else if (pick == 6)
            send_region(lead, comment, FLAW_SIGNATURE);
        else if (pick == 7)
            send_region(lead, comment, FLAW_SUM);
        else if (pick == 8)
            send_region(lead, comment, $urandom_range(0, 1) ? FLAW_TRUNCATED : FLAW_OPEN);
        else
        begin
            // Random bytes with stray start and end marks
            n = $urandom_range(1, 40);
            for (int k = 0; k < n; k++)
                send_byte(8'($urandom), k == 0 || $urandom_range(0, 31) == 0,
                          k == n - 1 || $urandom_range(0, 15) == 0);
        end
    endtask

    // Record at position zero ending on the last byte, a byte after the scan
    // finished, and a region too short to hold a record
    task automatic test_directed();
        logic [7:0] bytes [$];
        set_length_limit('1);
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        bytes = '{SIG_0, SIG_1, SIG_2, SIG_3};
        repeat (16)
            bytes.push_back(8'h00);
        bytes.push_back(8'hFF);
        bytes.push_back(8'hFF);
        foreach (bytes[k])
            send_byte(bytes[k], k == 0, k == bytes.size() - 1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
    endtask

    // With no room every byte is ignored and only end marks report
    task automatic test_zero_limit();
        set_length_limit('0);
        repeat (4)
            random_region(30, 1'b0);
    endtask

    // Small limits: rejections, ignored tails, lengths right at the limit
    task automatic test_tight_limit();
        int lim;
        int lead;
        int goal;
        repeat (4)
        begin
            lim = $urandom_range(RECORD_BYTES, 150);
            set_length_limit(LEN_W'(lim));
            goal = bytes_taken + 100;
            while (bytes_taken < goal)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    lead = $urandom_range(0, lim - RECORD_BYTES);
                    send_region(lead, lim - RECORD_BYTES - lead + $urandom_range(0, 1),
                                FLAW_NONE);
                end
                else
                    random_region(2 * lim, 1'b0);
            end
        end
    endtask

    task automatic test_wide_limit();
        int goal;
        set_length_limit(LEN_W'({$urandom, $urandom}));
        goal = bytes_taken + 300;
        while (bytes_taken < goal)
            random_region(200, 1'b0);
    endtask

    task automatic test_open_limit();
        int goal;
        set_length_limit('1);
        goal = bytes_taken + 500;
        while (bytes_taken < goal)
            random_region(200, 1'b0);
    endtask

    // Back-to-back transfers on both sides
    task automatic test_steady_stream();
        int goal;
        set_length_limit(LEN_W'($urandom_range(60, 100000)));
        goal = bytes_taken + 300;
        while (bytes_taken < goal)
            random_region(100, 1'b1);
    endtask

    initial
    begin
        clear_region();
        length_limit = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_zero_limit();
        test_tight_limit();
        test_wide_limit();
        test_open_limit();
        test_steady_stream();
        wait_quiet();
        if (mismatches == 0)
        begin
            $display("zip_end_record_locator verification clean");
        end
        else
        begin
            $display("zip_end_record_locator verification failed");
        end
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #10ms;
        $display("zip_end_record_locator verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/core/zel_pkg.sv
rtl/core/zel_in_stage.sv
rtl/core/zel_scan.sv
rtl/core/zip_end_record_locator.sv
dv/zip_end_record_locator_test.sv
